[src/lcsc_pkg.sv]
// Package for the load-cell scale controller: widths, codes and constants.
// Depends on nothing; used by the interfaces and the top level.
package lcsc_pkg;

  localparam int unsigned SampleBits = 24;
  localparam int unsigned HoldTicks  = 20;

  localparam int unsigned DivW = 14;
  localparam int unsigned ChW  = 4;

  localparam logic [DivW-1:0] CalDefault = 14'd13500;
  localparam logic [DivW-1:0] CalLow     = 14'd10000;
  localparam logic [DivW-1:0] CalHigh    = 14'd15000;
  localparam logic [DivW-1:0] CalStep    = 14'd100;
  localparam int unsigned     OverLimit  = 10000;
  localparam int unsigned     UnderLimit = 1000;

  localparam logic [ChW-1:0] ChMinus = 4'd10;
  localparam logic [ChW-1:0] ChOver  = 4'd11;
  localparam logic [ChW-1:0] ChUnder = 4'd12;

  localparam logic [0:0] RegTare = 1'b0;
  localparam logic [0:0] RegCal  = 1'b1;

  typedef struct packed {
    logic        sample_valid;
    logic [23:0] sample_value;
    logic        tare_pressed;
    logic        up_pressed;
    logic        down_pressed;
    logic        unit_pressed;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  digit_three;
    logic [3:0]  digit_two;
    logic [3:0]  digit_one;
    logic [3:0]  digit_zero;
    logic        calibrating;
    logic        save_tare;
    logic [23:0] tare_out;
    logic        save_calibration;
    logic [13:0] calibration_out;
    logic        at_upper_limit;
    logic        at_lower_limit;
  } out_item_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [23:0] data;
  } cfg_item_t;

  // Validate a stored divisor: only values strictly inside the band are kept.
  function automatic logic [DivW-1:0] validated_cal(input logic [15:0] v);
    if (v > 16'(CalLow) && v < 16'(CalHigh)) begin
      return v[DivW-1:0];
    end
    return CalDefault;
  endfunction

endpackage

[src/lcsc_if.sv]
// Handshake channel interfaces for the scale controller.
// Depends on lcsc_pkg for the payload types.
interface lcsc_in_if;
  logic               valid;
  logic               ready;
  lcsc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lcsc_out_if;
  logic                valid;
  logic                ready;
  lcsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lcsc_cfg_if;
  logic                valid;
  logic                ready;
  lcsc_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/load_cell_scale_controller_top.sv]
// Scale controller top level: debouncers, calibration control, shared divider.
// Depends on lcsc_pkg and the channel interfaces in lcsc_if.sv.
//
//  channel   | dir | payload
//  in_ch     | in  | sample and four button levels
//  out_ch    | out | four characters, mode, save pulses, tare and divisor
//  cfg_ch    | in  | register index (0 tare, 1 calibration) and data
//
// A tick without a sample outside calibration mode goes from the idle state
// through the control state to the output state. A sample adds one division of
// 25 restoring steps, one per cycle, and a digit pass (range check, then repeated
// subtractions for each digit); calibration mode adds a second division and digit
// pass. The two passes share the subtractors. Reset loads the register defaults.
// The input is refused while an item is in work, its result waits or a
// configuration write is offered; configuration is taken only in the idle state.
module load_cell_scale_controller_top #(
  parameter int unsigned SAMPLE_BITS = lcsc_pkg::SampleBits,
  parameter int unsigned HOLD_TICKS  = lcsc_pkg::HoldTicks
) (
  input logic        clk_i,
  input logic        rst_ni,
  lcsc_in_if.sink    in_ch,
  lcsc_out_if.source out_ch,
  lcsc_cfg_if.sink   cfg_ch
);
  import lcsc_pkg::*;

  localparam int unsigned QW = 25;
  localparam int unsigned QCW = $clog2(QW + 1);
  localparam logic [QCW-1:0] QLast = QCW'(QW - 1);
  localparam int unsigned HW = $clog2(HOLD_TICKS + 1);
  localparam logic [HW-1:0] HoldMax = HW'(HOLD_TICKS);
  localparam logic [23:0] SMask = 24'((33'd1 << SAMPLE_BITS) - 33'd1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_DIGIT, S_CTRL, S_DIV2, S_DIGIT2, S_OUT
  } state_e;

  state_e state_q;
  logic [23:0] tare_q, last_q;
  logic [DivW-1:0] act_q, work_q;
  logic calib_q;
  logic [HW-1:0] cnt_q [5];
  logic fired_q [5];
  logic [ChW-1:0] ch_q [4];
  in_item_t item_q;
  out_item_t res_q;
  // Divider state: sign, magnitude remainder and quotient.
  logic neg_q;
  logic [QW-1:0] num_q, quo_q;
  logic [DivW:0] rem_q;
  logic [DivW-1:0] dvs_q;
  logic [QCW-1:0] bit_q;
  // Digit extraction state.
  logic [1:0] dig_q;
  logic [13:0] val_q;
  logic [3:0] cntd_q;

  // One restoring step.
  logic [DivW+1:0] trial;
  assign trial = {rem_q, num_q[QW-1]} - {2'b0, dvs_q};

  // Digit weights, most significant first.
  logic [13:0] wgt;
  always_comb begin
    case (dig_q)
      2'd0: wgt = 14'd1000;
      2'd1: wgt = 14'd100;
      2'd2: wgt = 14'd10;
      default: wgt = 14'd1;
    endcase
  end

  // Debounce step.
  function automatic logic [HW+1:0] deb(input logic [HW-1:0] c, input logic f,
                                        input logic lv);
    logic [HW-1:0] n;
    n = c;
    if (!lv) return '0;
    if (n < HoldMax) n = n + HW'(1);
    if (n == HoldMax && !f) return {1'b1, 1'b1, {HW{1'b0}}};
    return {1'b0, f, n};
  endfunction

  assign in_ch.ready  = (state_q == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_q == S_IDLE);
  assign out_ch.valid = (state_q == S_OUT) && (bit_q == QCW'(1));
  assign out_ch.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [HW+1:0] r;
    logic [DivW-1:0] wd, ad;
    logic cm, fu, ft, ul, ll;
    logic [24:0] diff;
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tare_q <= '0; last_q <= '0;
      act_q <= CalDefault; work_q <= CalDefault;
      calib_q <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        cnt_q[i] <= '0; fired_q[i] <= 1'b0;
      end
      for (int i = 0; i < 4; i++) ch_q[i] <= '0;
      item_q <= '0; res_q <= '0;
      neg_q <= 1'b0; num_q <= '0; quo_q <= '0; rem_q <= '0; dvs_q <= CalDefault;
      bit_q <= '0; dig_q <= '0; val_q <= '0; cntd_q <= '0;
    end else begin
      diff = '0;
      case (state_q)
        S_IDLE: begin
          if (cfg_ch.valid) begin
            if (cfg_ch.data.index == RegTare) begin
              tare_q <= cfg_ch.data.data;
            end else begin
              act_q  <= validated_cal(cfg_ch.data.data[15:0]);
              work_q <= validated_cal(cfg_ch.data.data[15:0]);
            end
          end else if (in_ch.valid) begin
            item_q <= in_ch.data;
            if (in_ch.data.sample_valid) begin
              last_q <= in_ch.data.sample_value & SMask;
              diff = {1'b0, in_ch.data.sample_value & SMask} - {1'b0, tare_q};
              neg_q <= diff[24];
              num_q <= diff[24] ? -diff : diff;
              dvs_q <= act_q; rem_q <= '0; bit_q <= '0;
              state_q <= S_DIV;
            end else begin
              state_q <= S_CTRL;
            end
          end
        end
        S_DIV, S_DIV2: begin
          if (!trial[DivW+1]) rem_q <= trial[DivW:0];
          else rem_q <= {rem_q[DivW-1:0], num_q[QW-1]};
          quo_q <= {quo_q[QW-2:0], ~trial[DivW+1]};
          num_q <= {num_q[QW-2:0], 1'b0};
          bit_q <= bit_q + QCW'(1);
          if (bit_q == QLast) begin
            dig_q <= '0; cntd_q <= '0;
            state_q <= (state_q == S_DIV) ? S_DIGIT : S_DIGIT2;
          end
        end
        S_DIGIT, S_DIGIT2: begin
          if (dig_q == 2'd0 && cntd_q == 4'd0 && val_q == 14'd0 && bit_q != '0) begin
            // First cycle: range check and load of magnitude.
            bit_q <= '0;
            if (!neg_q && quo_q > QW'(OverLimit)) begin
              for (int i = 0; i < 4; i++) ch_q[i] <= ChOver;
              state_q <= (state_q == S_DIGIT) ? S_CTRL : S_OUT;
            end else if (neg_q && quo_q > QW'(UnderLimit)) begin
              for (int i = 0; i < 4; i++) ch_q[i] <= ChUnder;
              state_q <= (state_q == S_DIGIT) ? S_CTRL : S_OUT;
            end else begin
              val_q <= quo_q[13:0];
              if (quo_q == '0) begin
                for (int i = 0; i < 4; i++) ch_q[i] <= '0;
                state_q <= (state_q == S_DIGIT) ? S_CTRL : S_OUT;
              end
            end
          end else if (val_q >= wgt) begin
            val_q <= val_q - wgt;
            cntd_q <= cntd_q + 4'd1;
          end else begin
            ch_q[dig_q] <= (dig_q == 2'd0 && neg_q) ? ChMinus : cntd_q;
            cntd_q <= '0;
            dig_q <= dig_q + 2'd1;
            if (dig_q == 2'd3) begin
              val_q <= '0;
              state_q <= (state_q == S_DIGIT) ? S_CTRL : S_OUT;
            end
          end
        end
        S_CTRL: begin
          wd = work_q; ad = act_q; cm = calib_q; fu = 1'b0; ul = 1'b0; ll = 1'b0;
          r = deb(cnt_q[0], fired_q[0], item_q.up_pressed && item_q.down_pressed);
          cnt_q[0] <= r[HW-1:0]; fired_q[0] <= r[HW];
          if (r[HW+1]) cm = 1'b1;
          if (cm) begin
            r = deb(cnt_q[4], fired_q[4], item_q.unit_pressed);
            cnt_q[4] <= r[HW-1:0]; fired_q[4] <= r[HW];
            if (r[HW+1]) begin
              ad = wd; fu = 1'b1;
            end
            r = deb(cnt_q[1], fired_q[1], item_q.tare_pressed);
            cnt_q[1] <= r[HW-1:0]; fired_q[1] <= r[HW];
            if (r[HW+1]) wd = ad;
            r = deb(cnt_q[2], fired_q[2], item_q.up_pressed);
            cnt_q[2] <= r[HW-1:0]; fired_q[2] <= r[HW];
            if (r[HW+1]) begin
              if (wd < CalHigh) wd = wd + CalStep;
              else ul = 1'b1;
            end
            r = deb(cnt_q[3], fired_q[3], item_q.down_pressed);
            cnt_q[3] <= r[HW-1:0]; fired_q[3] <= r[HW];
            if (r[HW+1]) begin
              if (wd > CalLow) wd = wd - CalStep;
              else ll = 1'b1;
            end
            work_q <= wd; act_q <= ad;
            calib_q <= ~fu;
            res_q.save_tare <= 1'b0;
            res_q.save_calibration <= fu;
            res_q.at_upper_limit <= ul;
            res_q.at_lower_limit <= ll;
            res_q.calibrating <= ~fu;
            res_q.calibration_out <= ad;
            res_q.tare_out <= tare_q;
            diff = {1'b0, last_q} - {1'b0, tare_q};
            neg_q <= diff[24];
            num_q <= diff[24] ? -diff : diff;
            dvs_q <= wd; rem_q <= '0; bit_q <= '0;
            state_q <= S_DIV2;
          end else begin
            r = deb(cnt_q[1], fired_q[1], item_q.tare_pressed);
            cnt_q[1] <= r[HW-1:0]; fired_q[1] <= r[HW];
            ft = r[HW+1];
            if (ft) tare_q <= last_q;
            res_q.save_tare <= ft;
            res_q.save_calibration <= 1'b0;
            res_q.at_upper_limit <= 1'b0;
            res_q.at_lower_limit <= 1'b0;
            res_q.tare_out <= ft ? last_q : tare_q;
            res_q.calibrating <= 1'b0;
            res_q.calibration_out <= ad;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          res_q.digit_three <= ch_q[0];
          res_q.digit_two   <= ch_q[1];
          res_q.digit_one   <= ch_q[2];
          res_q.digit_zero  <= ch_q[3];
          if (out_ch.ready && bit_q == QCW'(1)) begin
            bit_q <= '0;
            state_q <= S_IDLE;
          end else begin
            bit_q <= QCW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
